### hw/rtl/row_softmax_scaled_masked_defines.svh
// Assertion macros for the row softmax block.
// Used by the checker; needs clk and rst_n in the scope of each use.
`ifndef ROW_SOFTMAX_SCALED_MASKED_DEFINES_SVH
`define ROW_SOFTMAX_SCALED_MASKED_DEFINES_SVH

// check a property while out of reset
`define RSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every edge, reset included
`define RSM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/rsm_pkg.sv
// Shared types, widths, register codes and the exp table for the row softmax.
// No dependencies.
package rsm_pkg;

  localparam int MAX_ROW    = 64;
  localparam int ADDR_W     = $clog2(MAX_ROW);
  localparam int CNT_W      = 7;
  localparam int VAL_W      = 16;
  localparam int PROB_W     = 17;
  localparam int SUM_W      = 23;
  localparam int INV_W      = 18;
  localparam int DIV_W      = 33;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_ENABLE = 2'd2;

  localparam logic signed [VAL_W-1:0] VAL_NEG_INF = 16'sh8000;
  localparam logic signed [VAL_W-1:0] VAL_POS_MAX = 16'sh7FFF;
  localparam logic [PROB_W-1:0]       ONE_Q16     = 17'd65536;

  typedef struct packed {
    logic [CNT_W-1:0] row_length;
    logic [15:0]      score_scale;
    logic             mask_enable;
  } cfg_t;

  function automatic logic [15:0] expk(input logic [3:0] k);
    logic [15:0] v;
    case (k)
      4'd0:    v = 16'd65280;
      4'd1:    v = 16'd65026;
      4'd2:    v = 16'd64520;
      4'd3:    v = 16'd63520;
      4'd4:    v = 16'd61565;
      4'd5:    v = 16'd57835;
      4'd6:    v = 16'd51039;
      4'd7:    v = 16'd39750;
      4'd8:    v = 16'd24109;
      4'd9:    v = 16'd8869;
      4'd10:   v = 16'd1200;
      4'd11:   v = 16'd22;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/rsm_in_if.sv
// Input channel of the row softmax: valid, ready, score and mask value.
// Depends on nothing.
interface rsm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] score;
  logic signed [15:0] mask_value;
  modport source (output valid, output score, output mask_value, input ready);
  modport sink (input valid, input score, input mask_value, output ready);
endinterface

### hw/rtl/rsm_out_if.sv
// Result channel of the row softmax: valid, ready, probability and row end.
// Depends on nothing.
interface rsm_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] probability;
  logic        row_end;
  modport source (output valid, output probability, output row_end, input ready);
  modport sink (input valid, input probability, input row_end, output ready);
endinterface

### hw/rtl/rsm_front.sv
// Front end: accepts items, scales the score, adds the mask when enabled and saturates.
// Depends on rsm_pkg and rsm_in_if.
module rsm_front
  import rsm_pkg::*;
(
  input  cfg_t                    cfg,
  rsm_in_if.sink                  in_ch,
  input  logic                    q_full,
  output logic                    push,
  output logic signed [VAL_W-1:0] push_data
);

  logic signed [32:0] prod;
  logic signed [33:0] biased;
  logic signed [25:0] scaled;
  logic signed [26:0] masked;

  assign prod   = in_ch.score * $signed({1'b0, cfg.score_scale});
  assign biased = {prod[32], prod} + 34'sd128;
  assign scaled = biased[33:8];

  always_comb begin
    masked = {scaled[25], scaled};
    if (cfg.mask_enable) begin
      if (in_ch.mask_value == VAL_NEG_INF) begin
        masked = 27'(VAL_NEG_INF);
      end else begin
        masked = {scaled[25], scaled} + 27'(in_ch.mask_value);
      end
    end
    if (masked > 27'(VAL_POS_MAX)) begin
      push_data = VAL_POS_MAX;
    end else if (masked < 27'(VAL_NEG_INF)) begin
      push_data = VAL_NEG_INF;
    end else begin
      push_data = masked[VAL_W-1:0];
    end
  end

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

endmodule

### hw/rtl/rsm_queue.sv
// Two-entry queue of scaled values between the front and back ends.
// Depends on rsm_pkg.
module rsm_queue
  import rsm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  logic signed [VAL_W-1:0] push_data,
  output logic                    full,
  input  logic                    pop,
  output logic                    q_valid,
  output logic signed [VAL_W-1:0] q_data
);

  logic signed [VAL_W-1:0] slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] level_r;

  assign full    = (level_r == 2'd2);
  assign q_valid = (level_r != 2'd0);
  assign q_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      level_r <= level_r + 2'(push) - 2'(pop);
    end
  end

endmodule

### hw/rtl/rsm_back.sv
// Back end: stores the row, forms exp terms, divides once and normalizes.
// Depends on rsm_pkg and rsm_out_if.
module rsm_back
  import rsm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [CNT_W-1:0]        row_length,
  input  logic                    q_valid,
  input  logic signed [VAL_W-1:0] q_data,
  output logic                    pop,
  rsm_out_if.source               out_ch
);

  localparam logic [2:0] S_ING   = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_EXP0  = 3'd2;
  localparam logic [2:0] S_EXPK  = 3'd3;
  localparam logic [2:0] S_DINIT = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_NRD   = 3'd6;
  localparam logic [2:0] S_NOUT  = 3'd7;

  logic signed [VAL_W-1:0] vmem [MAX_ROW];
  logic [PROB_W-1:0]       emem [MAX_ROW];
  logic signed [VAL_W-1:0] vrd_r;
  logic [PROB_W-1:0]       erd_r;

  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        n_r, n_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic signed [VAL_W-1:0] max_r, max_nxt;
  logic [11:0]             d_r, d_nxt;
  logic [3:0]              k_r, k_nxt;
  logic [PROB_W-1:0]       r_r, r_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [DIV_W-1:0]        q_r, q_nxt;
  logic [SUM_W:0]          rem_r, rem_nxt;
  logic [5:0]              dcnt_r, dcnt_nxt;
  logic [INV_W-1:0]        inv_r, inv_nxt;
  logic                    ov_r, ov_nxt;
  logic [PROB_W-1:0]       op_r, op_nxt;
  logic                    oe_r, oe_nxt;

  logic              v_we, e_we;
  logic [PROB_W-1:0] e_wdata;
  logic [CNT_W-1:0]  eff_len;
  logic [CNT_W-1:0]  cnt_inc, idx_inc;
  logic [16:0]       diff;
  logic [32:0]       kprod;
  logic [33:0]       kround;
  logic [SUM_W:0]    rem_sh;
  logic [34:0]       pprod;
  logic [35:0]       pround;
  logic [19:0]       pval;

  assign eff_len = (row_length == '0) ? CNT_W'(1) :
                   (row_length > CNT_W'(MAX_ROW)) ? CNT_W'(MAX_ROW) : row_length;
  assign cnt_inc = cnt_r + CNT_W'(1);
  assign idx_inc = idx_r + CNT_W'(1);
  assign diff    = {max_r[15], max_r} - {vrd_r[15], vrd_r};
  assign kprod   = r_r * expk(k_r);
  assign kround  = {1'b0, kprod} + 34'd32768;
  assign rem_sh  = {rem_r[SUM_W-1:0], q_r[DIV_W-1]};
  assign pprod   = erd_r * inv_r;
  assign pround  = {1'b0, pprod} + 36'd32768;
  assign pval    = pround[35:16];

  assign pop = (state_r == S_ING) && q_valid;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    max_nxt   = max_r;
    d_nxt     = d_r;
    k_nxt     = k_r;
    r_nxt     = r_r;
    sum_nxt   = sum_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    dcnt_nxt  = dcnt_r;
    inv_nxt   = inv_r;
    ov_nxt    = ov_r && !out_ch.ready;
    op_nxt    = op_r;
    oe_nxt    = oe_r;
    v_we      = 1'b0;
    e_we      = 1'b0;
    e_wdata   = '0;
    case (state_r)
      S_ING: begin
        if (q_valid) begin
          v_we    = 1'b1;
          cnt_nxt = cnt_inc;
          if (q_data > max_r) begin
            max_nxt = q_data;
          end
          if (cnt_inc >= eff_len) begin
            n_nxt     = cnt_inc;
            cnt_nxt   = '0;
            idx_nxt   = '0;
            sum_nxt   = '0;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_EXP0;
      end
      S_EXP0: begin
        if ((vrd_r == VAL_NEG_INF && max_r != VAL_NEG_INF) || diff[15:12] != 4'd0) begin
          e_we    = 1'b1;
          e_wdata = '0;
          idx_nxt = idx_inc;
          state_nxt = (idx_inc == n_r) ? S_DINIT : S_RD;
        end else begin
          d_nxt     = diff[11:0];
          r_nxt     = ONE_Q16;
          k_nxt     = '0;
          state_nxt = S_EXPK;
        end
      end
      S_EXPK: begin
        if (d_r[k_r]) begin
          r_nxt = kround[32:16];
        end
        k_nxt = k_r + 4'd1;
        if (k_r == 4'd11) begin
          e_we      = 1'b1;
          e_wdata   = r_nxt;
          sum_nxt   = sum_r + SUM_W'(r_nxt);
          idx_nxt   = idx_inc;
          state_nxt = (idx_inc == n_r) ? S_DINIT : S_RD;
        end
      end
      S_DINIT: begin
        q_nxt     = {1'b1, 32'd0} + DIV_W'(sum_r >> 1);
        rem_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, sum_r}) begin
          rem_nxt = rem_sh - {1'b0, sum_r};
          q_nxt   = {q_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          q_nxt   = {q_r[DIV_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 6'd1;
        if (dcnt_r == 6'(DIV_W - 1)) begin
          inv_nxt   = q_nxt[INV_W-1:0];
          idx_nxt   = '0;
          state_nxt = S_NRD;
        end
      end
      S_NRD: begin
        state_nxt = S_NOUT;
      end
      S_NOUT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt  = 1'b1;
          op_nxt  = (pval > 20'(ONE_Q16)) ? ONE_Q16 : pval[PROB_W-1:0];
          oe_nxt  = (idx_inc == n_r);
          idx_nxt = idx_inc;
          if (idx_inc == n_r) begin
            max_nxt   = VAL_NEG_INF;
            state_nxt = S_ING;
          end else begin
            state_nxt = S_NRD;
          end
        end
      end
      default: begin
        state_nxt = S_ING;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[cnt_r[ADDR_W-1:0]] <= q_data;
    end
    if (e_we) begin
      emem[idx_r[ADDR_W-1:0]] <= e_wdata;
    end
    vrd_r <= vmem[idx_r[ADDR_W-1:0]];
    erd_r <= emem[idx_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ING;
      cnt_r   <= '0;
      max_r   <= VAL_NEG_INF;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      max_r   <= max_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    idx_r  <= idx_nxt;
    d_r    <= d_nxt;
    k_r    <= k_nxt;
    r_r    <= r_nxt;
    sum_r  <= sum_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    dcnt_r <= dcnt_nxt;
    inv_r  <= inv_nxt;
    op_r   <= op_nxt;
    oe_r   <= oe_nxt;
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.probability = op_r;
  assign out_ch.row_end     = oe_r;

endmodule

### hw/rtl/row_softmax_scaled_masked.sv
// Row softmax top level: configuration registers, front end, queue, back end.
// Depends on rsm_pkg, rsm_in_if, rsm_out_if, rsm_front, rsm_queue, rsm_back.
// Ingest: one item per cycle until a row of n items is held.
// Exp pass: each element is read, then its term is built by multiply steps (skipped when zero), one shared multiplier.
// Reciprocal: one quotient bit per cycle; then each output passes S_NRD and S_NOUT, held while the result stalls.
// Reset (synchronous, rst_n low): registers to 64 / 1.0 / off, row empty, no output.
module row_softmax_scaled_masked
  import rsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rsm_in_if.sink                in_ch,
  rsm_out_if.source             out_ch
);

  cfg_t                    cfg_r;
  logic                    push, q_full, pop, q_valid;
  logic signed [VAL_W-1:0] push_data, q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_length  <= CNT_W'(MAX_ROW);
      cfg_r.score_scale <= 16'd256;
      cfg_r.mask_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_LENGTH:  cfg_r.row_length  <= cfg_data[CNT_W-1:0];
        CFG_SCORE_SCALE: cfg_r.score_scale <= cfg_data;
        CFG_MASK_ENABLE: cfg_r.mask_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rsm_front u_front (
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  rsm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  rsm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .row_length (cfg_r.row_length),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

### hw/rtl/rsm_checker.sv
// Port-level checks on the row softmax result channel, bound to the top level.
// Depends on rsm_pkg and row_softmax_scaled_masked_defines.svh.
`include "row_softmax_scaled_masked_defines.svh"
module rsm_checker
  import rsm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [PROB_W-1:0] out_probability,
  input logic              out_row_end
);

  `RSM_ASSERT_ALWAYS(a_idle_after_reset, !rst_n |=> !out_valid, "result valid after reset")
  `RSM_ASSERT(a_prob_bound, out_valid |-> out_probability <= ONE_Q16, "probability above one")
  `RSM_ASSERT(a_hold_valid, out_valid && !out_ready |=> out_valid, "result dropped")
  `RSM_ASSERT(a_hold_data, out_valid && !out_ready |=> $stable(out_probability) && $stable(out_row_end), "result changed while stalled")

endmodule

bind row_softmax_scaled_masked rsm_checker u_rsm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_probability (out_ch.probability),
  .out_row_end     (out_ch.row_end)
);

### dv/tb_row_softmax_scaled_masked.sv
// Self-checking testbench for row_softmax_scaled_masked: scaled, masked row softmax.
// Needs rsm_pkg, rsm_in_if, rsm_out_if and the block's RTL; predicts every output in place.
`timescale 1ns / 1ps

module tb_row_softmax_scaled_masked;
  import rsm_pkg::*;

  typedef struct {
    logic [PROB_W-1:0] prob;
    logic              last;
  } prob_item_t;

  localparam int unsigned EXP_TBL [12] = '{65280, 65026, 64520, 63520, 61565, 57835,
                                           51039, 39750, 24109, 8869, 1200, 22};

  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rsm_in_if  in_ch ();
  rsm_out_if out_ch ();

  row_softmax_scaled_masked u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor state
  int          row_len_reg = 64;
  int          scale_reg   = 256;
  bit          mask_en_reg = 1'b0;
  int          row_vals [MAX_ROW];
  int          held_count  = 0;
  int          row_max     = -32768;
  prob_item_t  prob_q [$];

  int  err_count    = 0;
  int  items_sent   = 0;
  bit  tx_quiet     = 1'b0;
  bit  rx_quiet     = 1'b0;
  int  rx_hold_req  = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned exp_term(int d);
    longint unsigned r;
    if (d >= 4096) return 0;
    r = 65536;
    for (int k = 0; k < 12; k++)
      if ((d >> k) & 1) r = (r * EXP_TBL[k] + 32768) >> 16;
    return int'(r);
  endfunction

  function automatic int eff_row_len();
    if (row_len_reg < 1) return 1;
    if (row_len_reg > MAX_ROW) return MAX_ROW;
    return row_len_reg;
  endfunction

  function automatic void predict_softmax(logic signed [15:0] sc, logic signed [15:0] mk);
    longint          v;
    longint unsigned sum;
    longint unsigned inv;
    longint unsigned p;
    int unsigned     eterm [MAX_ROW];
    prob_item_t      it;
    v = (longint'(sc) * longint'(scale_reg) + 128) >>> 8;
    if (mask_en_reg) begin
      if (mk == VAL_NEG_INF) v = -32768;
      else v = v + longint'(mk);
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    if (held_count >= MAX_ROW) held_count = 0;
    row_vals[held_count] = int'(v);
    if (int'(v) > row_max) row_max = int'(v);
    held_count++;
    if (held_count < eff_row_len()) return;
    sum = 0;
    for (int i = 0; i < held_count; i++) begin
      if (row_vals[i] == -32768 && row_max != -32768) eterm[i] = 0;
      else eterm[i] = exp_term(row_max - row_vals[i]);
      sum += eterm[i];
    end
    inv = (sum == 0) ? 0 : (((64'd1 << 32) + sum / 2) / sum);
    for (int i = 0; i < held_count; i++) begin
      p = (longint'(eterm[i]) * inv + 32768) >> 16;
      if (p > 65536) p = 65536;
      it.prob = p[PROB_W-1:0];
      it.last = (i + 1 == held_count);
      prob_q.push_back(it);
    end
    held_count = 0;
    row_max    = -32768;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    prob_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (prob_q.size() == 0) begin
        report_mismatch("unexpected item, probability", out_ch.probability, -1);
      end else begin
        want = prob_q.pop_front();
        if (out_ch.probability !== want.prob)
          report_mismatch("probability", out_ch.probability, want.prob);
        if (out_ch.row_end !== want.last)
          report_mismatch("row_end", out_ch.row_end, want.last);
      end
    end
  end

  // receiver ready, random stalls plus requested long hold
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!rx_quiet && $urandom_range(0, 99) < 25) begin
        hold_left = gap_len();
        out_ch.ready <= (hold_left == 0);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic signed [15:0] sc, logic signed [15:0] mk);
    int gap;
    gap = tx_quiet ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.score      <= sc;
    in_ch.mask_value <= mk;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_softmax(sc, mk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (prob_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ROW_LENGTH:  row_len_reg = int'(data[CNT_W-1:0]);
      CFG_SCORE_SCALE: scale_reg   = int'(data);
      CFG_MASK_ENABLE: mask_en_reg = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(int len, int scale, bit mask_en);
    wait_drained();
    write_reg(CFG_ROW_LENGTH, CFG_DATA_W'(len));
    write_reg(CFG_SCORE_SCALE, CFG_DATA_W'(scale));
    write_reg(CFG_MASK_ENABLE, CFG_DATA_W'(mask_en));
  endtask

  function automatic logic [15:0] rand_score(int base);
    if ($urandom_range(0, 1)) return 16'($urandom);
    return 16'(base + $signed($urandom_range(0, 1600)) - 800);
  endfunction

  function automatic logic [15:0] rand_mask();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return VAL_NEG_INF;
    if (r < 45) return 16'd0;
    if (r < 75) return 16'($signed($urandom_range(0, 2048)) - 1024);
    return 16'($urandom);
  endfunction

  task automatic send_row(int n);
    int base;
    base = $signed($urandom_range(0, 65535)) - 32768;
    for (int i = 0; i < n; i++) send_item(rand_score(base), rand_mask());
  endtask

  task automatic test_extremes();
    set_config(4, 256, 1'b0);
    send_item(16'sh7FFF, 16'sh7FFF);
    send_item(16'sh8000, 16'sh8000);
    send_item(16'sh0000, 16'sh0001);
    send_item(16'sh0001, 16'shFFFF);
    wait_drained();
    write_reg(CFG_NO_REG, 16'hFFFF);
    set_config(2, 65535, 1'b0);
    send_item(16'sh7FFF, 16'sh0000);
    send_item(16'sh8000, 16'sh0000);
    set_config(2, 0, 1'b0);
    send_item(16'sh1234, 16'sh0000);
    send_item(16'shC000, 16'sh0000);
    set_config(0, 256, 1'b0);
    send_item(16'sh0100, 16'sh0000);
  endtask

  task automatic test_mask();
    set_config(4, 256, 1'b1);
    send_item(16'sh0100, 16'sh8000);
    send_item(16'sh0200, 16'sh0000);
    send_item(16'sh7FFF, 16'sh7FFF);
    send_item(16'sh8000, 16'sh8001);
    set_config(3, 300, 1'b1);
    send_item(16'sh0100, 16'sh8000);
    send_item(16'sh7FFF, 16'sh8000);
    send_item(16'shFF00, 16'sh8000);
  endtask

  task automatic test_backpressure();
    set_config(8, 256, 1'b1);
    tx_quiet    = 1'b1;
    rx_hold_req = 400;
    repeat (3) send_row(8);
    tx_quiet = 1'b0;
    wait_drained();
    send_row(8);
  endtask

  task automatic test_random_rows(int item_goal);
    int r;
    int len;
    int scale;
    int n;
    int rows;
    while (items_sent < item_goal) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 8);
      else if (r < 80) len = $urandom_range(9, 63);
      else if (r < 85) len = 64;
      else if (r < 90) len = 127;
      else if (r < 95) len = 0;
      else len = $urandom_range(65, 126);
      r = $urandom_range(0, 99);
      if (r < 40) scale = 256;
      else if (r < 60) scale = $urandom_range(0, 65535);
      else if (r < 70) scale = 0;
      else if (r < 80) scale = 65535;
      else scale = $urandom_range(1, 1024);
      set_config(len, scale, $urandom_range(0, 1));
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      n = eff_row_len();
      rows = $urandom_range(1, 4);
      for (int j = 0; j < rows && items_sent < item_goal; j++) send_row(n);
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_ROW_LENGTH;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.score      <= '0;
    in_ch.mask_value <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_mask();
    test_backpressure();
    test_random_rows(370);
    wait_drained();
    repeat (200) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/rsm_pkg.sv
hw/rtl/rsm_in_if.sv
hw/rtl/rsm_out_if.sv
hw/rtl/rsm_front.sv
hw/rtl/rsm_queue.sv
hw/rtl/rsm_back.sv
hw/rtl/row_softmax_scaled_masked.sv
hw/rtl/rsm_checker.sv
dv/tb_row_softmax_scaled_masked.sv
